// ===== hw/rtl/sbch_pkg.sv =====
// Shared types, codes and constants of the SPI bootloader command host.
`default_nettype none

package sbch_pkg;

  // Largest payload that one write command may carry.
  localparam int unsigned MaxPayload = 256;
  // Most link bytes that one item can produce.
  localparam int unsigned ResMax = 8;
  localparam int unsigned ResCntW = $clog2(ResMax + 1);
  localparam int unsigned ResIdxW = $clog2(ResMax);

  // Protocol bytes.
  localparam logic [7:0] BYTE_ACK   = 8'h79;
  localparam logic [7:0] BYTE_NACK  = 8'h15;
  localparam logic [7:0] BYTE_SYNC  = 8'h5A;
  localparam logic [7:0] BYTE_WRITE = 8'h31;
  localparam logic [7:0] BYTE_ERASE = 8'h44;
  localparam logic [7:0] BYTE_ALL   = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  // Command codes of an input item.
  localparam logic [2:0] CMD_SYNC  = 3'd0;
  localparam logic [2:0] CMD_ERASE = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_DATA  = 3'd3;
  localparam logic [2:0] CMD_REPLY = 3'd4;

  // Status codes of a result item.
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_DONE   = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  // Command phase.
  typedef enum logic [7:0] {
    PH_IDLE       = 8'b0000_0001,
    PH_SYNC_ACK   = 8'b0000_0010,
    PH_ERASE_ACK1 = 8'b0000_0100,
    PH_ERASE_ACK2 = 8'b0000_1000,
    PH_WR_ACK1    = 8'b0001_0000,
    PH_WR_ACK2    = 8'b0010_0000,
    PH_WR_DATA    = 8'b0100_0000,
    PH_WR_ACK3    = 8'b1000_0000
  } sbch_phase_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] target_address;
    logic [7:0]  length_minus_one;
    logic [7:0]  data_byte;
    logic [7:0]  reply_byte;
  } sbch_in_t;

  typedef struct packed {
    logic       send;
    logic [7:0] tx_byte;
    logic       expect_reply;
    logic [1:0] status;
    logic       last;
  } sbch_res_t;

  typedef sbch_res_t [ResMax-1:0] sbch_res_list_t;

  // Sequencer state carried from one item to the next.
  typedef struct packed {
    sbch_phase_e phase;
    logic [31:0] pending_address;
    logic [7:0]  pending_length;
    logic [7:0]  running_checksum;
    logic [8:0]  bytes_left;
  } sbch_state_t;

  // One link transfer with no status attached yet.
  function automatic sbch_res_t res_byte(logic [7:0] b, logic exp_reply);
    sbch_res_t r;
    r.send         = 1'b1;
    r.tx_byte      = b;
    r.expect_reply = exp_reply;
    r.status       = ST_BUSY;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/spi_bootloader_command_host_core.sv =====
// Top level of the SPI bootloader command host: input register, sequencer state, result queue.
`default_nettype none

// Each accepted item is registered, then the sequencer works it out combinationally and
// loads its one to eight results into a result shift register, which hands one result
// per output transfer. An item holds the output until all of its results (eight at most,
// for the address stage of a write) have left; the next item is taken while those results drain
// and is loaded as the last of them leaves, so with no output stall the block sustains one
// result per clock. Each result but the status-only result of a rejected item is one link byte
// to shift out; the byte received on a result marked expect_reply must come back as a reply item.

module spi_bootloader_command_host_core import sbch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sbch_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sbch_res_t out_data_o
);

  sbch_in_t           item_q;
  logic               item_vld_q, item_vld_d;
  sbch_state_t        state_q, state_d, state_n;
  sbch_res_list_t     step_list;
  logic [ResCntW-1:0] step_cnt;
  logic [ResCntW-1:0] q_cnt;
  logic               q_free;
  logic               take;
  logic               in_xfer;

  // The held item moves on once the result queue can take its list.
  assign take       = item_vld_q && q_free;
  assign in_stall_o = item_vld_q && !q_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign item_vld_d = in_xfer || (item_vld_q && !take);
  assign state_d    = take ? state_n : state_q;

  sbch_step u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_n),
    .list_o  (step_list),
    .cnt_o   (step_cnt)
  );

  sbch_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .list_i      (step_list),
    .cnt_i       (step_cnt),
    .free_o      (q_free),
    .cnt_o       (q_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Input register valid flag and sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      state_q    <= '{phase: PH_IDLE, default: '0};
    end else begin
      item_vld_q <= item_vld_d;
      state_q    <= state_d;
    end
  end

  // Input item payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
  end

  // The result marked last is the only one left in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> q_cnt == ResCntW'(1))
    else $error("last result leaves with more results queued");

  // Every item loads between one and eight results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> step_cnt != '0 && step_cnt <= ResCntW'(ResMax))
    else $error("result count out of range");

  // The data phase always has bytes still to come.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_WR_DATA |-> state_q.bytes_left != 9'd0)
    else $error("data phase with no bytes left");

endmodule

`default_nettype wire

// ===== hw/rtl/sbch_step.sv =====
// Next-state and result-list logic for one item of the command host.
`default_nettype none

module sbch_step import sbch_pkg::*; (
  input  sbch_in_t               item_i,
  input  sbch_state_t            state_i,
  output sbch_state_t            state_o,
  output sbch_res_list_t         list_o,
  output logic [ResCntW-1:0]     cnt_o
);

  logic [7:0]         csum_n;
  logic [8:0]         left_n;
  logic [9:0]         len_total;
  logic               rej;
  logic [1:0]         st;
  logic [ResIdxW-1:0] last_idx;
  logic [ResCntW-1:0] cnt_m1;

  assign csum_n    = state_i.running_checksum ^ item_i.data_byte;
  assign left_n    = state_i.bytes_left - 9'd1;
  assign len_total = {2'b00, item_i.length_minus_one} + 10'd1;

  // Sequencing per command and phase.
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    a0 = state_i.pending_address[31:24];
    a1 = state_i.pending_address[23:16];
    a2 = state_i.pending_address[15:8];
    a3 = state_i.pending_address[7:0];
    state_o = state_i;
    list_o  = '0;
    cnt_o   = ResCntW'(1);
    st      = ST_BUSY;
    rej     = 1'b0;
    case (item_i.cmd)
      CMD_SYNC, CMD_ERASE, CMD_WRITE: begin
        if (state_i.phase != PH_IDLE) begin
          rej = 1'b1;
        end else if (item_i.cmd == CMD_SYNC) begin
          list_o[0] = res_byte(BYTE_SYNC, 1'b0);
          list_o[1] = res_byte(BYTE_ZERO, 1'b0);
          list_o[2] = res_byte(BYTE_ZERO, 1'b1);
          cnt_o = ResCntW'(3);
          state_o.phase = PH_SYNC_ACK;
        end else if (item_i.cmd == CMD_ERASE) begin
          list_o[0] = res_byte(BYTE_SYNC, 1'b0);
          list_o[1] = res_byte(BYTE_ERASE, 1'b0);
          list_o[2] = res_byte(~BYTE_ERASE, 1'b0);
          list_o[3] = res_byte(BYTE_ZERO, 1'b0);
          list_o[4] = res_byte(BYTE_ZERO, 1'b1);
          cnt_o = ResCntW'(5);
          state_o.phase = PH_ERASE_ACK1;
        end else if (len_total > 10'(MaxPayload)) begin
          rej = 1'b1;
        end else begin
          state_o.pending_address = item_i.target_address;
          state_o.pending_length  = item_i.length_minus_one;
          list_o[0] = res_byte(BYTE_SYNC, 1'b0);
          list_o[1] = res_byte(BYTE_WRITE, 1'b0);
          list_o[2] = res_byte(~BYTE_WRITE, 1'b0);
          list_o[3] = res_byte(BYTE_ZERO, 1'b0);
          list_o[4] = res_byte(BYTE_ZERO, 1'b1);
          cnt_o = ResCntW'(5);
          state_o.phase = PH_WR_ACK1;
        end
      end
      CMD_DATA: begin
        if (state_i.phase != PH_WR_DATA || state_i.bytes_left == 9'd0) begin
          rej = 1'b1;
        end else begin
          list_o[0] = res_byte(item_i.data_byte, 1'b0);
          state_o.running_checksum = csum_n;
          state_o.bytes_left       = left_n;
          if (left_n == 9'd0) begin
            list_o[1] = res_byte(csum_n, 1'b0);
            list_o[2] = res_byte(BYTE_ZERO, 1'b0);
            list_o[3] = res_byte(BYTE_ZERO, 1'b1);
            cnt_o = ResCntW'(4);
            state_o.phase = PH_WR_ACK3;
          end
        end
      end
      CMD_REPLY: begin
        if (!(state_i.phase inside {PH_SYNC_ACK, PH_ERASE_ACK1, PH_ERASE_ACK2,
                                    PH_WR_ACK1, PH_WR_ACK2, PH_WR_ACK3})) begin
          rej = 1'b1;
        end else begin
          list_o[0] = res_byte(BYTE_ACK, 1'b0);
          if (item_i.reply_byte != BYTE_ACK) begin
            // Negative or garbled acknowledge ends the command.
            state_o.phase = PH_IDLE;
            st = ST_FAIL;
          end else begin
            case (state_i.phase)
              PH_ERASE_ACK1: begin
                list_o[1] = res_byte(BYTE_ALL, 1'b0);
                list_o[2] = res_byte(BYTE_ALL, 1'b0);
                list_o[3] = res_byte(BYTE_ALL ^ BYTE_ALL, 1'b0);
                list_o[4] = res_byte(BYTE_ZERO, 1'b0);
                list_o[5] = res_byte(BYTE_ZERO, 1'b1);
                cnt_o = ResCntW'(6);
                state_o.phase = PH_ERASE_ACK2;
              end
              PH_WR_ACK1: begin
                list_o[1] = res_byte(a0, 1'b0);
                list_o[2] = res_byte(a1, 1'b0);
                list_o[3] = res_byte(a2, 1'b0);
                list_o[4] = res_byte(a3, 1'b0);
                list_o[5] = res_byte(a0 ^ a1 ^ a2 ^ a3, 1'b0);
                list_o[6] = res_byte(BYTE_ZERO, 1'b0);
                list_o[7] = res_byte(BYTE_ZERO, 1'b1);
                cnt_o = ResCntW'(8);
                state_o.phase = PH_WR_ACK2;
              end
              PH_WR_ACK2: begin
                list_o[1] = res_byte(state_i.pending_length, 1'b0);
                cnt_o = ResCntW'(2);
                state_o.running_checksum = state_i.pending_length;
                state_o.bytes_left       = {1'b0, state_i.pending_length} + 9'd1;
                state_o.phase            = PH_WR_DATA;
              end
              default: begin
                state_o.phase = PH_IDLE;
                st = ST_DONE;
              end
            endcase
          end
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase

    // A rejected item leaves the state alone and yields one status result.
    if (rej) begin
      state_o = state_i;
      list_o  = '0;
      cnt_o   = ResCntW'(1);
      st      = ST_REJECT;
    end

    // Status and end marker go on the final result.
    cnt_m1   = cnt_o - ResCntW'(1);
    last_idx = cnt_m1[ResIdxW-1:0];
    list_o[last_idx].status = st;
    list_o[last_idx].last   = 1'b1;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbch_outq.sv =====
// Result shift register that hands an item's results out one per transfer.
`default_nettype none

module sbch_outq import sbch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sbch_res_list_t     list_i,
  input  logic [ResCntW-1:0] cnt_i,
  output logic               free_o,
  output logic [ResCntW-1:0] cnt_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbch_res_t          out_data_o
);

  sbch_res_list_t     list_q, list_d;
  logic [ResCntW-1:0] cnt_q, cnt_d;
  logic               xfer;

  assign out_valid_o = (cnt_q != '0);
  assign xfer        = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == '0) || (cnt_q == ResCntW'(1) && !out_stall_i);
  assign out_data_o  = list_q[0];
  assign cnt_o       = cnt_q;

  // Load a new list, or drop the entry that just left.
  always_comb begin
    list_d = list_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      list_d = list_i;
      cnt_d  = cnt_i;
    end else if (xfer) begin
      list_d = {sbch_res_t'('0), list_q[ResMax-1:1]};
      cnt_d  = cnt_q - ResCntW'(1);
    end
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    list_q <= list_d;
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench of the SPI bootloader command host: directed and random command streams checked per byte.
module tb;
  import sbch_pkg::*;

  localparam int unsigned IdleMax     = 16;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomItems = 200;
  localparam int unsigned DrainCycles = 20;

  // Predicts the link bytes of every accepted item and keeps them until they come out.
  class link_byte_tracker;
    sbch_phase_e phase;
    logic [31:0] pending_address;
    logic [7:0]  pending_length;
    logic [7:0]  running_checksum;
    logic [8:0]  bytes_left;
    sbch_res_t   item_bytes[$];
    sbch_res_t   awaited_bytes[$];
    int unsigned errors;

    function new();
      phase            = PH_IDLE;
      pending_address  = '0;
      pending_length   = '0;
      running_checksum = '0;
      bytes_left       = '0;
      errors           = 0;
    endfunction

    function void add_byte(logic [7:0] b, logic exp_reply);
      sbch_res_t r;
      r.send         = 1'b1;
      r.tx_byte      = b;
      r.expect_reply = exp_reply;
      r.status       = ST_BUSY;
      r.last         = 1'b0;
      item_bytes.push_back(r);
    endfunction

    // Two zero bytes; the byte received on the second one comes back as a reply.
    function void add_ack_frame();
      add_byte(BYTE_ZERO, 1'b0);
      add_byte(BYTE_ZERO, 1'b1);
    endfunction

    // The status rides on the final byte of the item.
    function void close_item(logic [1:0] status);
      item_bytes[item_bytes.size() - 1].status = status;
      item_bytes[item_bytes.size() - 1].last   = 1'b1;
      foreach (item_bytes[i]) awaited_bytes.push_back(item_bytes[i]);
      item_bytes.delete();
    endfunction

    // A rejected item gives a single status-only result and leaves the state alone.
    function void reject_item();
      sbch_res_t r;
      item_bytes.delete();
      r = '0;
      item_bytes.push_back(r);
      close_item(ST_REJECT);
    endfunction

    function void note_item(sbch_in_t it);
      logic [7:0] a3, a2, a1, a0;
      item_bytes.delete();
      if (it.cmd == CMD_SYNC || it.cmd == CMD_ERASE || it.cmd == CMD_WRITE) begin
        if (phase != PH_IDLE || (it.cmd == CMD_WRITE &&
            int'(it.length_minus_one) + 1 > int'(MaxPayload))) begin
          reject_item();
        end else begin
          add_byte(BYTE_SYNC, 1'b0);
          if (it.cmd == CMD_SYNC) begin
            phase = PH_SYNC_ACK;
          end else if (it.cmd == CMD_ERASE) begin
            add_byte(BYTE_ERASE, 1'b0);
            add_byte(~BYTE_ERASE, 1'b0);
            phase = PH_ERASE_ACK1;
          end else begin
            pending_address = it.target_address;
            pending_length  = it.length_minus_one;
            add_byte(BYTE_WRITE, 1'b0);
            add_byte(~BYTE_WRITE, 1'b0);
            phase = PH_WR_ACK1;
          end
          add_ack_frame();
          close_item(ST_BUSY);
        end
      end else if (it.cmd == CMD_DATA) begin
        if (phase != PH_WR_DATA || bytes_left == 0) begin
          reject_item();
        end else begin
          // Each data byte goes out as it arrives; the checksum follows the last one.
          add_byte(it.data_byte, 1'b0);
          running_checksum = running_checksum ^ it.data_byte;
          bytes_left = bytes_left - 9'd1;
          if (bytes_left == 0) begin
            add_byte(running_checksum, 1'b0);
            add_ack_frame();
            phase = PH_WR_ACK3;
          end
          close_item(ST_BUSY);
        end
      end else if (it.cmd != CMD_REPLY || phase == PH_IDLE || phase == PH_WR_DATA) begin
        reject_item();
      end else begin
        // The acknowledge byte is sent whether or not the reply was good.
        add_byte(BYTE_ACK, 1'b0);
        if (it.reply_byte != BYTE_ACK) begin
          phase = PH_IDLE;
          close_item(ST_FAIL);
        end else begin
          case (phase)
            PH_ERASE_ACK1: begin
              add_byte(BYTE_ALL, 1'b0);
              add_byte(BYTE_ALL, 1'b0);
              add_byte(BYTE_ZERO, 1'b0);
              add_ack_frame();
              phase = PH_ERASE_ACK2;
              close_item(ST_BUSY);
            end
            PH_WR_ACK1: begin
              a3 = pending_address[31:24];
              a2 = pending_address[23:16];
              a1 = pending_address[15:8];
              a0 = pending_address[7:0];
              add_byte(a3, 1'b0);
              add_byte(a2, 1'b0);
              add_byte(a1, 1'b0);
              add_byte(a0, 1'b0);
              add_byte(a3 ^ a2 ^ a1 ^ a0, 1'b0);
              add_ack_frame();
              phase = PH_WR_ACK2;
              close_item(ST_BUSY);
            end
            PH_WR_ACK2: begin
              add_byte(pending_length, 1'b0);
              running_checksum = pending_length;
              bytes_left = {1'b0, pending_length} + 9'd1;
              phase = PH_WR_DATA;
              close_item(ST_BUSY);
            end
            default: begin
              phase = PH_IDLE;
              close_item(ST_DONE);
            end
          endcase
        end
      end
    endfunction

    function void check_result(sbch_res_t got);
      sbch_res_t want;
      if (awaited_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: send %b tx %h reply %b status %0d last %b",
                 $time, got.send, got.tx_byte, got.expect_reply, got.status, got.last);
      end else begin
        want = awaited_bytes.pop_front();
        if (got.send !== want.send || got.tx_byte !== want.tx_byte ||
            got.expect_reply !== want.expect_reply || got.status !== want.status ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch: expected send %b tx %h reply %b status %0d last %b",
                   $time, want.send, want.tx_byte, want.expect_reply, want.status, want.last);
          $display("%0t:           actual send %b tx %h reply %b status %0d last %b",
                   $time, got.send, got.tx_byte, got.expect_reply, got.status, got.last);
        end
      end
    endfunction

    function int unsigned outstanding();
      return awaited_bytes.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  sbch_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  sbch_res_t out_data;

  localparam int unsigned CmdSpace = 2 ** $bits(in_data.cmd);

  bit tx_no_gaps    = 1'b0;
  bit rx_no_gaps    = 1'b0;
  bit long_hold_req = 1'b0;
  int unsigned quiet_cycles = 0;
  link_byte_tracker tracker;

  spi_bootloader_command_host_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one item after a random gap and holds it until the transfer.
  task automatic push_item(sbch_in_t it);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, IdleMax);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_item(it);
    @(negedge clk);
  endtask

  function automatic sbch_in_t rand_item(logic [2:0] c);
    sbch_in_t it;
    it.cmd              = c;
    it.target_address   = $urandom;
    it.length_minus_one = 8'($urandom);
    it.data_byte        = 8'($urandom);
    it.reply_byte       = 8'($urandom);
    return it;
  endfunction

  task automatic push_cmd(logic [2:0] c);
    push_item(rand_item(c));
  endtask

  task automatic push_reply(logic [7:0] b);
    sbch_in_t it;
    it = rand_item(CMD_REPLY);
    it.reply_byte = b;
    push_item(it);
  endtask

  task automatic push_data(logic [7:0] b);
    sbch_in_t it;
    it = rand_item(CMD_DATA);
    it.data_byte = b;
    push_item(it);
  endtask

  task automatic push_write(logic [31:0] addr, logic [7:0] lenm1);
    sbch_in_t it;
    it = rand_item(CMD_WRITE);
    it.target_address   = addr;
    it.length_minus_one = lenm1;
    push_item(it);
  endtask

  // Mostly good acknowledges, some NACKs and some arbitrary bytes.
  function automatic logic [7:0] pick_reply();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return BYTE_ACK;
    if (r == 8) return BYTE_NACK;
    return 8'($urandom);
  endfunction

  // Picks the item that fits the current phase, with occasional noise.
  task automatic step_stream();
    sbch_in_t it;
    it = rand_item(3'($urandom_range(0, CmdSpace - 1)));
    if ($urandom_range(0, 11) != 0) begin
      if (tracker.phase == PH_IDLE) begin
        case ($urandom_range(0, 2))
          0:       it.cmd = CMD_SYNC;
          1:       it.cmd = CMD_ERASE;
          default: it.cmd = CMD_WRITE;
        endcase
        it.length_minus_one = ($urandom_range(0, 24) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(0, 15));
      end else if (tracker.phase == PH_WR_DATA) begin
        it.cmd = CMD_DATA;
      end else begin
        it.cmd        = CMD_REPLY;
        it.reply_byte = pick_reply();
      end
    end
    push_item(it);
  endtask

  // The sender stops offering until every predicted byte has come out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.outstanding() != 0);
  endtask

  // Result side: random stalls before each transfer, with a long hold on request.
  initial begin
    int unsigned hold;
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end else begin
        if ($urandom_range(0, 31) == 0) rx_no_gaps = !rx_no_gaps;
        hold = rx_no_gaps ? 0 : $urandom_range(0, IdleMax);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned sent;
    tracker = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Items that do not fit the idle phase, and the unused command codes.
    push_reply(BYTE_ACK);
    push_data(8'h3C);
    for (int c = CMD_REPLY + 1; c < CmdSpace; c++) push_cmd(3'(c));

    // Sync completed, then a sync interrupted by a command and failed by a NACK.
    push_cmd(CMD_SYNC);
    push_reply(BYTE_ACK);
    push_cmd(CMD_SYNC);
    push_cmd(CMD_ERASE);
    push_reply(BYTE_NACK);

    // Mass erase through both acknowledges.
    push_cmd(CMD_ERASE);
    push_reply(BYTE_ACK);
    push_reply(BYTE_ACK);

    // Single-byte write to the top address.
    push_write('1, 8'd0);
    push_reply(BYTE_ACK);
    push_reply(BYTE_ACK);
    push_data(8'hFF);
    push_reply(BYTE_ACK);

    // Two-byte write to address zero, a reply during data, and a failed final ack.
    push_write('0, 8'd1);
    push_reply(BYTE_ACK);
    push_reply(BYTE_ACK);
    push_data(8'h00);
    push_reply(BYTE_ACK);
    push_data(8'hA5);
    push_reply(BYTE_ZERO);
    wait_drain();

    // Random command streams that follow the protocol with noise mixed in.
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 19) == 0) tx_no_gaps = !tx_no_gaps;
      step_stream();
      sent++;
    end
    while (tracker.phase != PH_IDLE) step_stream();

    // A sixteen-byte write offered back to back while the result side holds off.
    tx_no_gaps    = 1'b1;
    long_hold_req = 1'b1;
    push_write($urandom, 8'd15);
    push_reply(BYTE_ACK);
    push_reply(BYTE_ACK);
    repeat (16) push_data(8'($urandom));
    push_reply(BYTE_ACK);
    wait_drain();

    repeat (DrainCycles) @(negedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sbch_pkg.sv
hw/rtl/sbch_step.sv
hw/rtl/sbch_outq.sv
hw/rtl/spi_bootloader_command_host_core.sv
bench/tb.sv
